// ===== rtl/asfc_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and codes for the audio sample format converter
// no dependencies; used by asfc_decode, asfc_pack and the top level
package asfc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned SAMPLE_W = 33;

    // input encodings
    localparam logic [1:0] ENC_U8_MIX   = 2'd0;
    localparam logic [1:0] ENC_S16_PAIR = 2'd1;
    localparam logic [1:0] ENC_S32_MONO = 2'd2;
    localparam logic [1:0] ENC_NONE     = 2'd3;

    // output formats
    localparam logic [2:0] FMT_INT16   = 3'd0;
    localparam logic [2:0] FMT_INT32   = 3'd1;
    localparam logic [2:0] FMT_UINT8   = 3'd2;
    localparam logic [2:0] FMT_FLOAT32 = 3'd3;
    localparam logic [2:0] FMT_ZEROS   = 3'd4;

    // register indexes
    localparam logic [3:0] REG_INPUT_ENCODING = 4'd0;
    localparam logic [3:0] REG_OUTPUT_FORMAT  = 4'd1;

    // reset values
    localparam logic [1:0] ENC_RESET = ENC_S16_PAIR;
    localparam logic [2:0] FMT_RESET = FMT_INT16;

    // 2^29 = 127 * MIX_K + 2
    localparam logic [22:0] MIX_K     = 23'd4227330;
    // floor(y / 127) = (y * RECIP_127) >> 19 for y < 4096
    localparam logic [12:0] RECIP_127 = 13'd4129;
    localparam logic [31:0] Q_ONE     = 32'h8000_0000;
    localparam logic [14:0] SCALE_S16 = 15'd32767;
    localparam logic signed [7:0] SCALE_U8 = 8'sd127;
    localparam logic [7:0] U8_BIAS   = 8'd128;

    localparam logic [3:0] BYTES_U8  = 4'd2;
    localparam logic [3:0] BYTES_S16 = 4'd4;
    localparam logic [3:0] BYTES_WIDE = 4'd8;

endpackage

// ===== rtl/asfc_decode.sv =====
`timescale 1ns / 1ps
// two-stage decoder: source frame word to clamped q31 left and right samples
// depends on asfc_pkg
module asfc_decode
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [1:0]                             enc,
    input  logic [asfc_pkg::WORD_W-1:0]            word,
    output logic signed [asfc_pkg::SAMPLE_W-1:0]   left,
    output logic signed [asfc_pkg::SAMPLE_W-1:0]   right
);

    logic [9:0]         byte_sum;
    logic signed [10:0] mix_s;
    logic               mix_neg;
    logic [9:0]         mix_abs;
    logic [10:0]        mix_mag;
    logic [11:0]        fine_num;
    logic [33:0]        coarse_prod;
    logic [24:0]        fine_prod;

    logic [1:0]                      enc_reg;
    logic                            neg_reg;
    logic [asfc_pkg::WORD_W-1:0]     word_reg;
    logic [33:0]                     coarse_reg;
    logic [5:0]                      fine_reg;

    logic [33:0]                          mix_q;
    logic [31:0]                          mix_qc;
    logic signed [asfc_pkg::SAMPLE_W-1:0] mix_v;
    logic signed [asfc_pkg::SAMPLE_W-1:0] left_next;
    logic signed [asfc_pkg::SAMPLE_W-1:0] right_next;
    logic signed [asfc_pkg::SAMPLE_W-1:0] left_reg;
    logic signed [asfc_pkg::SAMPLE_W-1:0] right_reg;

    // stage 1: byte mix and constant multiplies
    always_comb
    begin
        byte_sum    = 10'(word[7:0]) + 10'(word[15:8]) + 10'(word[23:16]) + 10'(word[31:24]);
        mix_s       = $signed({1'b0, byte_sum}) - 11'sd512;
        mix_neg     = mix_s[10];
        mix_abs     = mix_neg ? 10'(-mix_s) : mix_s[9:0];
        mix_mag     = {mix_abs, 1'b0} + 11'(mix_abs);
        fine_num    = {mix_mag, 1'b0} + 12'd63;
        coarse_prod = 34'(mix_mag) * 34'(asfc_pkg::MIX_K);
        fine_prod   = 25'(fine_num) * 25'(asfc_pkg::RECIP_127);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            enc_reg    <= enc;
            neg_reg    <= mix_neg;
            word_reg   <= word;
            coarse_reg <= coarse_prod;
            fine_reg   <= fine_prod[24:19];
        end
    end

    // stage 2: finish the mix, clamp, select encoding
    always_comb
    begin
        mix_q  = coarse_reg + 34'(fine_reg);
        mix_qc = (mix_q > 34'(asfc_pkg::Q_ONE)) ? asfc_pkg::Q_ONE : mix_q[31:0];
        mix_v  = neg_reg ? -$signed({1'b0, mix_qc}) : $signed({1'b0, mix_qc});
        unique case (enc_reg)
            asfc_pkg::ENC_U8_MIX:
            begin
                left_next  = mix_v;
                right_next = mix_v;
            end
            asfc_pkg::ENC_S16_PAIR:
            begin
                left_next  = $signed({{1{word_reg[15]}}, word_reg[15:0], 16'd0});
                right_next = $signed({{1{word_reg[31]}}, word_reg[31:16], 16'd0});
            end
            asfc_pkg::ENC_S32_MONO:
            begin
                left_next  = $signed({word_reg[31], word_reg});
                right_next = $signed({word_reg[31], word_reg});
            end
            asfc_pkg::ENC_NONE:
            begin
                left_next  = '0;
                right_next = '0;
            end
            default:
            begin
                left_next  = '0;
                right_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign left  = left_reg;
    assign right = right_reg;

endmodule

// ===== rtl/asfc_pack.sv =====
`timescale 1ns / 1ps
// two-stage packer: q31 sample to int16, int32, uint8, float32 or zeros
// depends on asfc_pkg
module asfc_pack
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [2:0]                             fmt,
    input  logic signed [asfc_pkg::SAMPLE_W-1:0]   sample,
    output logic [asfc_pkg::WORD_W-1:0]            word
);

    logic                sign;
    logic [31:0]         mag;
    logic [4:0]          lz;
    logic [46:0]         prod16;
    logic signed [40:0]  prod8;

    logic [2:0]          fmt_reg;
    logic                sign_reg;
    logic [31:0]         mag_reg;
    logic [4:0]          lz_reg;
    logic [15:0]         p16_reg;
    logic signed [9:0]   p8_reg;

    logic [31:0] norm;
    logic        round_up;
    logic [24:0] mant;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [31:0] q32;
    logic [15:0] s16;
    logic [9:0]  u8;
    logic [asfc_pkg::WORD_W-1:0] word_next;
    logic [asfc_pkg::WORD_W-1:0] word_reg;

    // stage 3: magnitude, leading zeros, scale multiplies
    always_comb
    begin
        sign   = sample[asfc_pkg::SAMPLE_W-1];
        mag    = sign ? 32'(-sample) : sample[31:0];
        lz     = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
            begin
                lz = 5'(31 - i);
            end
        end
        prod16 = 47'(mag) * 47'(asfc_pkg::SCALE_S16);
        prod8  = 41'(sample) * 41'(asfc_pkg::SCALE_U8);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fmt_reg  <= fmt;
            sign_reg <= sign;
            mag_reg  <= mag;
            lz_reg   <= lz;
            p16_reg  <= prod16[46:31];
            p8_reg   <= prod8[40:31];
        end
    end

    // stage 4: normalize and round, final format select
    always_comb
    begin
        norm     = mag_reg << lz_reg;
        round_up = norm[7] & ((|norm[6:0]) | norm[8]);
        mant     = {1'b0, norm[31:8]} + 25'(round_up);
        expo     = 8'd127 - 8'(lz_reg) + 8'(mant[24]);
        frac     = mant[24] ? mant[23:1] : mant[22:0];
        q32      = (mag_reg == 32'd0) ? 32'd0 : mag_reg - 32'd1;
        s16      = sign_reg ? -p16_reg : p16_reg;
        u8       = p8_reg + 10'(asfc_pkg::U8_BIAS);
        unique case (fmt_reg)
            asfc_pkg::FMT_INT16:   word_next = 32'(s16);
            asfc_pkg::FMT_INT32:   word_next = sign_reg ? -q32 : q32;
            asfc_pkg::FMT_UINT8:   word_next = 32'(u8[7:0]);
            asfc_pkg::FMT_FLOAT32:
            begin
                word_next = (mag_reg == 32'd0) ? 32'd0 : {sign_reg, expo, frac};
            end
            default:               word_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

// ===== rtl/audio_sample_format_converter_top.sv =====
`timescale 1ns / 1ps
// audio sample format converter: one source frame word in, one stereo frame out
// takes one item per cycle while the output is not stalled, through a four-stage pipeline
// (two decode stages and two pack stages); an item is registered in each stage in turn
// and the whole pipeline holds while the output item is not taken.
// depends on asfc_pkg, asfc_decode, asfc_pack
module audio_sample_format_converter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // frame_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // left_word, right_word, frame_bytes, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic        pipe_en;
    logic [1:0]  enc_reg;
    logic [2:0]  fmt_reg;
    logic        vld1_reg;
    logic        vld2_reg;
    logic        vld3_reg;
    logic        vld4_reg;
    logic [3:0]  bytes_next;
    logic [3:0]  bytes_reg;

    logic signed [asfc_pkg::SAMPLE_W-1:0] left_q;
    logic signed [asfc_pkg::SAMPLE_W-1:0] right_q;
    logic [asfc_pkg::WORD_W-1:0]          left_word;
    logic [asfc_pkg::WORD_W-1:0]          right_word;

    assign pipe_en   = !vld4_reg || m_tready;
    assign s_tready  = pipe_en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg <= asfc_pkg::ENC_RESET;
            fmt_reg <= asfc_pkg::FMT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == asfc_pkg::REG_INPUT_ENCODING)
            begin
                enc_reg <= cfg_data[1:0];
            end
            else if (cfg_index == asfc_pkg::REG_OUTPUT_FORMAT)
            begin
                fmt_reg <= cfg_data[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            vld1_reg <= s_tvalid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    asfc_decode u_decode
    (
        .clk    (clk),
        .en     (pipe_en),
        .enc    (enc_reg),
        .word   (s_tdata),
        .left   (left_q),
        .right  (right_q)
    );

    asfc_pack u_pack_left
    (
        .clk    (clk),
        .en     (pipe_en),
        .fmt    (fmt_reg),
        .sample (left_q),
        .word   (left_word)
    );

    asfc_pack u_pack_right
    (
        .clk    (clk),
        .en     (pipe_en),
        .fmt    (fmt_reg),
        .sample (right_q),
        .word   (right_word)
    );

    always_comb
    begin
        unique case (fmt_reg)
            asfc_pkg::FMT_INT16: bytes_next = asfc_pkg::BYTES_S16;
            asfc_pkg::FMT_UINT8: bytes_next = asfc_pkg::BYTES_U8;
            default:             bytes_next = asfc_pkg::BYTES_WIDE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            bytes_reg <= bytes_next;
        end
    end

    assign m_tvalid = vld4_reg;
    assign m_tdata  = {4'd0, bytes_reg, right_word, left_word};

    // an item taken while the pipeline keeps moving reaches the output once it has passed the remaining stages
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready ##1 pipe_en ##1 pipe_en ##1 pipe_en) |=> m_tvalid)
    else $error("item lost in pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[67:64] == asfc_pkg::BYTES_U8 ||
                      m_tdata[67:64] == asfc_pkg::BYTES_S16 ||
                      m_tdata[67:64] == asfc_pkg::BYTES_WIDE))
    else $error("bad frame byte count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[67:64] == asfc_pkg::BYTES_U8) |->
        (m_tdata[31:8] == 24'd0 && m_tdata[7:0] != 8'd0 &&
         m_tdata[63:40] == 24'd0 && m_tdata[39:32] != 8'd0))
    else $error("uint8 sample out of range");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench for audio_sample_format_converter_top: streams frame words through the
// converter, predicts every output frame and checks them in order
// depends on asfc_pkg and the converter rtl
module tb;

    localparam longint UNIT = 64'sd2147483648;

    typedef struct {
        logic [31:0] left_word;
        logic [31:0] right_word;
        logic [3:0]  frame_bytes;
    } stereo_frame_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [7:0]  cfg_data;

    logic [1:0]    conv_enc;
    logic [2:0]    conv_fmt;
    stereo_frame_t pending_frames[$];
    int            mismatch_count;
    int            idle_pct;
    int            stall_pct;
    int            hold_serial;
    int            hold_len;
    int            hold_seen = 0;
    int            hold_left = 0;

    audio_sample_format_converter_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic longint clamp_unit(input longint v);
        if (v > UNIT)
            return UNIT;
        if (v < -UNIT)
            return -UNIT;
        return v;
    endfunction

    function automatic void decode_channels(input logic [31:0] word, output longint l,
                                            output longint r);
        longint s;
        longint unsigned mag;
        longint unsigned q;
        l = 0;
        r = 0;
        if (conv_enc == asfc_pkg::ENC_U8_MIX)
        begin
            s = 0;
            for (int i = 0; i < 4; i++)
                s += longint'(word[8*i +: 8]) - 64'sd128;
            mag = (s < 0) ? -s : s;
            mag = mag * 3;
            q = ((mag << 29) + 63) / 127;
            if (q > 64'd2147483648)
                q = 64'd2147483648;
            l = (s < 0) ? -longint'(q) : longint'(q);
            r = l;
        end
        else if (conv_enc == asfc_pkg::ENC_S16_PAIR)
        begin
            l = longint'($signed(word[15:0])) * 65536;
            r = longint'($signed(word[31:16])) * 65536;
        end
        else if (conv_enc == asfc_pkg::ENC_S32_MONO)
        begin
            l = longint'($signed(word));
            r = l;
        end
        l = clamp_unit(l);
        r = clamp_unit(r);
    endfunction

    // truncates v * k / 2^31 toward zero
    function automatic longint scale_trunc(input longint v, input longint unsigned k);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? -v : v;
        q = (mag * k) >> 31;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] to_single(input longint v);
        logic            sign;
        longint unsigned m;
        longint unsigned mant;
        longint unsigned rem;
        longint unsigned half;
        int              p;
        int              sh;
        logic [7:0]      expo;
        sign = (v < 0);
        m = (v < 0) ? -v : v;
        if (m == 0)
            return 32'd0;
        p = 0;
        while (p < 40 && (m >> (p + 1)) != 0)
            p++;
        if (p <= 23)
            mant = m << (23 - p);
        else
        begin
            sh = p - 23;
            rem = m & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            mant = m >> sh;
            if (rem > half || (rem == half && mant[0]))
                mant++;
            if ((mant >> 24) != 0)
            begin
                mant = mant >> 1;
                p++;
            end
        end
        expo = 8'(p + 127 - 31);
        return {sign, expo, mant[22:0]};
    endfunction

    function automatic logic [31:0] pack_sample(input longint v);
        longint t;
        case (conv_fmt)
            asfc_pkg::FMT_INT16:
            begin
                t = scale_trunc(v, 32767);
                return {16'd0, t[15:0]};
            end
            asfc_pkg::FMT_INT32:
            begin
                t = scale_trunc(v, 2147483647);
                return t[31:0];
            end
            asfc_pkg::FMT_UINT8:
            begin
                t = (v * 127 + UNIT * 128) >>> 31;
                if (t > 255)
                    t = 255;
                return t[31:0];
            end
            asfc_pkg::FMT_FLOAT32:
                return to_single(v);
            default:
                return 32'd0;
        endcase
    endfunction

    function automatic stereo_frame_t convert_frame(input logic [31:0] word);
        stereo_frame_t f;
        longint        l;
        longint        r;
        decode_channels(word, l, r);
        f.left_word = pack_sample(l);
        f.right_word = pack_sample(r);
        if (conv_fmt == asfc_pkg::FMT_INT16)
            f.frame_bytes = asfc_pkg::BYTES_S16;
        else if (conv_fmt == asfc_pkg::FMT_UINT8)
            f.frame_bytes = asfc_pkg::BYTES_U8;
        else
            f.frame_bytes = asfc_pkg::BYTES_WIDE;
        return f;
    endfunction

    function automatic void add_expected(input stereo_frame_t f);
        pending_frames.insert(pending_frames.size(), f);
    endfunction

    function automatic logic [31:0] random_frame_word();
        logic [31:0] w;
        logic [7:0]  picks[7];
        picks = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'h81, 8'hfe, 8'hff};
        w = $urandom;
        case ($urandom_range(3))
            1:
                for (int i = 0; i < 4; i++)
                    w[8*i +: 8] = 8'($urandom_range(96, 160));
            2:
                w = $unsigned($signed(w) >>> $urandom_range(31));
            3:
                for (int i = 0; i < 4; i++)
                    w[8*i +: 8] = picks[$urandom_range(6)];
            default:
                ;
        endcase
        return w;
    endfunction

    task automatic send_frame(input logic [31:0] word);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata <= $urandom;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do
            @(posedge clk);
        while (!s_tready);
        add_expected(convert_frame(word));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == asfc_pkg::REG_INPUT_ENCODING)
            conv_enc = value[1:0];
        else if (index == asfc_pkg::REG_OUTPUT_FORMAT)
            conv_fmt = value[2:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input logic [1:0] enc, input logic [2:0] fmt);
        logic [7:0] d;
        wait_drain();
        d = 8'($urandom);
        d[1:0] = enc;
        write_reg(asfc_pkg::REG_INPUT_ENCODING, d);
        d = 8'($urandom);
        d[2:0] = fmt;
        write_reg(asfc_pkg::REG_OUTPUT_FORMAT, d);
    endtask

    task automatic test_reset_state();
        send_frame(32'h0000_0000);
        send_frame(32'h7fff_8000);
        send_frame(32'h8000_7fff);
        send_frame(32'hffff_0001);
        wait_drain();
    endtask

    task automatic test_directed_frames();
        set_mode(asfc_pkg::ENC_U8_MIX, asfc_pkg::FMT_FLOAT32);
        send_frame(32'h0000_0000);
        send_frame(32'hffff_ffff);
        send_frame(32'h8080_8080);
        send_frame(32'h7f7f_7f7f);
        send_frame(32'h8180_8080);
        set_mode(asfc_pkg::ENC_S32_MONO, asfc_pkg::FMT_UINT8);
        send_frame(32'h8000_0000);
        send_frame(32'h7fff_ffff);
        send_frame(32'hffff_ffff);
        send_frame(32'h0000_0001);
        send_frame(32'h4000_0000);
        set_mode(asfc_pkg::ENC_NONE, asfc_pkg::FMT_INT32);
        send_frame(32'hdead_beef);
        send_frame(32'hffff_ffff);
        set_mode(asfc_pkg::ENC_S16_PAIR, asfc_pkg::FMT_INT32);
        send_frame(32'h8000_7fff);
        send_frame(32'h0001_ffff);
        wait_drain();
    endtask

    task automatic test_register_decode();
        for (int i = 2; i < 16; i++)
            write_reg(i[3:0], 8'($urandom));
        for (int f = asfc_pkg::FMT_ZEROS; f < 8; f++)
        begin
            set_mode(asfc_pkg::ENC_S32_MONO, f[2:0]);
            send_frame(32'h8000_0000);
            send_frame(32'h1234_5678);
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        set_mode(asfc_pkg::ENC_S16_PAIR, asfc_pkg::FMT_FLOAT32);
        idle_pct = 0;
        stall_pct = 0;
        hold_len = 150;
        hold_serial++;
        repeat (40) send_frame(random_frame_word());
        wait_drain();
    endtask

    task automatic test_random_stream();
        int idle_table[4];
        int stall_table[4];
        int f;
        idle_table = '{0, 56, 0, 30};
        stall_table = '{0, 0, 56, 30};
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = idle_table[phase];
            stall_pct = stall_table[phase];
            for (int k = 0; k < 4; k++)
            begin
                f = (phase * 4 + k) % 8;
                set_mode(k[1:0], f[2:0]);
                repeat (30) send_frame(random_frame_word());
            end
        end
        wait_drain();
    endtask

    // receiver side: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_serial != hold_seen)
        begin
            hold_seen = hold_serial;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge clk)
    begin
        stereo_frame_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_frames.size() == 0)
                report_mismatch("unexpected item", 32'd0, m_tdata[31:0]);
            else
            begin
                want = pending_frames.pop_front();
                if (m_tdata[31:0] !== want.left_word)
                    report_mismatch("left_word", want.left_word, m_tdata[31:0]);
                if (m_tdata[63:32] !== want.right_word)
                    report_mismatch("right_word", want.right_word, m_tdata[63:32]);
                if (m_tdata[67:64] !== want.frame_bytes)
                    report_mismatch("frame_bytes", {28'd0, want.frame_bytes},
                                    {28'd0, m_tdata[67:64]});
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        conv_enc = asfc_pkg::ENC_RESET;
        conv_fmt = asfc_pkg::FMT_RESET;
        mismatch_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_serial = 0;
        hold_len = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed_frames();
        test_register_decode();
        test_backpressure();
        test_random_stream();

        wait_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_frames.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
